// ----- hdl/sobel_pkg.sv -----
// Shared constants and types for the Sobel edge threshold block.
`timescale 1ns / 1ps
package sobel_pkg;

	localparam int CFG_ADDR_BITS   = 2;
	localparam int CFG_DATA_BITS   = 12;
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 12;
	localparam int LEVEL_BITS      = 8;
	localparam int ROW_BITS        = 12;
	localparam int OUT_COL_BITS    = 10;
	localparam int OUT_PAD_BITS    = 2;
	localparam int OUT_TDATA_BITS  = 32;

	localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_VALUE    = 2'd2;

	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 12'd1024;
	localparam logic [LEVEL_BITS-1:0]      LEVEL_RESET  = 8'd255;
	localparam logic [HEIGHT_REG_BITS-1:0] MIN_HEIGHT   = 12'd3;

	typedef struct packed {
		logic [OUT_PAD_BITS-1:0] pad;
		logic [OUT_COL_BITS-1:0] center_col;
		logic [ROW_BITS-1:0]     center_row;
		logic [LEVEL_BITS-1:0]   edge_value;
	} out_beat_t;

endpackage

// ----- hdl/sobel_line_store.sv -----
// Two line stores held as one memory with registered read data.
`timescale 1ns / 1ps
module sobel_line_store
	import sobel_pkg::*;
#(
	parameter int PIXEL_BITS = 8,
	parameter int DEPTH      = 1024,
	parameter int ADDR_BITS  = 10
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [ADDR_BITS-1:0]  rd_addr,
	output logic [PIXEL_BITS-1:0] rd_upper,
	output logic [PIXEL_BITS-1:0] rd_middle,
	input  logic                  wr_en,
	input  logic [ADDR_BITS-1:0]  wr_addr,
	input  logic [PIXEL_BITS-1:0] wr_upper,
	input  logic [PIXEL_BITS-1:0] wr_middle
);

	logic [2*PIXEL_BITS-1:0] mem [DEPTH];
	logic [2*PIXEL_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_upper, wr_middle};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_upper  = rd_data_q[2*PIXEL_BITS-1:PIXEL_BITS];
	assign rd_middle = rd_data_q[PIXEL_BITS-1:0];

endmodule

// ----- hdl/sobel_kernel.sv -----
// Sobel gradient magnitude over a 3x3 window and threshold decision.
`timescale 1ns / 1ps
module sobel_kernel
	import sobel_pkg::*;
#(
	parameter int PIXEL_BITS = 8
) (
	input  logic [PIXEL_BITS-1:0] a0,
	input  logic [PIXEL_BITS-1:0] a1,
	input  logic [PIXEL_BITS-1:0] a2,
	input  logic [PIXEL_BITS-1:0] b0,
	input  logic [PIXEL_BITS-1:0] b2,
	input  logic [PIXEL_BITS-1:0] c0,
	input  logic [PIXEL_BITS-1:0] c1,
	input  logic [PIXEL_BITS-1:0] c2,
	input  logic [LEVEL_BITS-1:0] level,
	output logic [LEVEL_BITS-1:0] edge_value
);

	localparam int SUM_BITS = PIXEL_BITS + 2;
	localparam int MAG_BITS = PIXEL_BITS + 3;
	localparam int CMP_BITS = (MAG_BITS > LEVEL_BITS) ? MAG_BITS + 1 : LEVEL_BITS + 1;

	logic [SUM_BITS-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
	logic [SUM_BITS-1:0] gx_abs, gy_abs;
	logic [MAG_BITS-1:0] mag;

	always_comb begin
		gx_pos = SUM_BITS'(c0) + SUM_BITS'({c1, 1'b0}) + SUM_BITS'(c2);
		gx_neg = SUM_BITS'(a0) + SUM_BITS'({a1, 1'b0}) + SUM_BITS'(a2);
		gy_pos = SUM_BITS'(a2) + SUM_BITS'({b2, 1'b0}) + SUM_BITS'(c2);
		gy_neg = SUM_BITS'(a0) + SUM_BITS'({b0, 1'b0}) + SUM_BITS'(c0);
		gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
		gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
		mag    = MAG_BITS'(gx_abs) + MAG_BITS'(gy_abs);
		edge_value = (CMP_BITS'(mag) > CMP_BITS'(level)) ? level : '0;
	end

endmodule

// ----- hdl/sobel_edge_threshold.sv -----
// Top level of the 3x3 Sobel edge detector with threshold output.
// A result passes through stage one and the output register before it is presented on the output.
// Throughput: one pixel per cycle unless stalled by m_axis_tready; line store read and write once per cycle.
// Pixels on the first two rows and columns of a frame give no result.
// Reset (arst_n low, asynchronous) clears the position, the window and the pipeline valids
// and loads width 1024, height 1024 and level 255; line store contents are not cleared.
`timescale 1ns / 1ps
module sobel_edge_threshold
	import sobel_pkg::*;
#(
	parameter int PIXEL_BITS     = 8,
	parameter int MAX_LINE_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// pixel
	input  logic [8*((PIXEL_BITS+7)/8)-1:0] s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// edge_value [7:0], center_row [19:8], center_col [29:20], zero [31:30]
	output logic [OUT_TDATA_BITS-1:0]    m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [CFG_ADDR_BITS-1:0]     cfg_addr,
	input  logic [CFG_DATA_BITS-1:0]     cfg_wdata
);

	localparam int COL_BITS = $clog2(MAX_LINE_WIDTH);
	localparam int WID_BITS = $clog2(MAX_LINE_WIDTH + 1);
	localparam int CMP_BITS = (WID_BITS > WIDTH_REG_BITS) ? WID_BITS : WIDTH_REG_BITS;
	localparam logic [CMP_BITS-1:0] MAX_W = CMP_BITS'(MAX_LINE_WIDTH);
	localparam logic [CMP_BITS-1:0] MIN_W = CMP_BITS'(3);

	logic [WIDTH_REG_BITS-1:0]  width_cfg_q;
	logic [HEIGHT_REG_BITS-1:0] height_cfg_q;
	logic [LEVEL_BITS-1:0]      level_cfg_q;

	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;

	logic                  valid_s1;
	logic                  result_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [ROW_BITS-1:0]   row_s1;

	logic [PIXEL_BITS-1:0] win_q [6];

	logic                  out_valid_q;
	out_beat_t             out_q;

	logic                  in_accept;
	logic                  out_free;
	logic                  adv_s1;
	logic [CMP_BITS-1:0]   width_eff;
	logic [ROW_BITS-1:0]   height_eff;
	logic [CMP_BITS-1:0]   col_inc;
	logic                  col_last;
	logic                  row_last;
	logic [PIXEL_BITS-1:0] top_rd;
	logic [PIXEL_BITS-1:0] mid_rd;
	logic [LEVEL_BITS-1:0] edge_calc;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_comb begin
		width_eff = CMP_BITS'(width_cfg_q);
		if (width_eff < MIN_W) begin
			width_eff = MIN_W;
		end else if (width_eff > MAX_W) begin
			width_eff = MAX_W;
		end
		height_eff = (height_cfg_q < MIN_HEIGHT) ? MIN_HEIGHT : height_cfg_q;
		col_inc    = CMP_BITS'(col_q) + CMP_BITS'(1);
		col_last   = col_inc >= width_eff;
		row_last   = (row_q + 12'd1) >= height_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= WIDTH_RESET;
			height_cfg_q <= HEIGHT_RESET;
			level_cfg_q  <= LEVEL_RESET;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_IMAGE_WIDTH: begin
						width_cfg_q <= cfg_wdata[WIDTH_REG_BITS-1:0];
						col_q       <= '0;
						row_q       <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						height_cfg_q <= cfg_wdata[HEIGHT_REG_BITS-1:0];
						col_q        <= '0;
						row_q        <= '0;
					end
					REG_MAX_VALUE: begin
						level_cfg_q <= cfg_wdata[LEVEL_BITS-1:0];
					end
					default: begin
					end
				endcase
			end else if (in_accept) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Stage one: the pixel waits here while the line store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			result_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1  <= 1'b1;
			result_s1 <= (row_q >= 12'd2) && (col_q >= COL_BITS'(2));
		end else if (adv_s1) begin
			valid_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1 <= s_axis_tdata[PIXEL_BITS-1:0];
			col_s1   <= col_q;
			row_s1   <= row_q;
		end
	end

	sobel_line_store #(
		.PIXEL_BITS (PIXEL_BITS),
		.DEPTH      (MAX_LINE_WIDTH),
		.ADDR_BITS  (COL_BITS)
	) u_line_store (
		.clk       (clk),
		.rd_en     (in_accept),
		.rd_addr   (col_q),
		.rd_upper  (top_rd),
		.rd_middle (mid_rd),
		.wr_en     (adv_s1),
		.wr_addr   (col_s1),
		.wr_upper  (mid_rd),
		.wr_middle (pixel_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= pixel_s1;
		end
	end

	sobel_kernel #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_kernel (
		.a0         (win_q[0]),
		.a1         (win_q[1]),
		.a2         (win_q[2]),
		.b0         (win_q[3]),
		.b2         (win_q[5]),
		.c0         (top_rd),
		.c1         (mid_rd),
		.c2         (pixel_s1),
		.level      (level_cfg_q),
		.edge_value (edge_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && result_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.pad        <= '0;
			out_q.center_col <= OUT_COL_BITS'(col_s1 - 1'b1);
			out_q.center_row <= row_s1 - 12'd1;
			out_q.edge_value <= edge_calc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule
